// File: rtl/stream_find_and_replace_defines.svh
// ----------------------------------------------------------------------------
// stream_find_and_replace_defines
// Assertion macros for the find-and-replace block. They are empty when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_AND_REPLACE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked at every edge outside reset.
`define SFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfr assertion failed");
// Checked at every edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT(lbl, prop)
`define SFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the find-and-replace cells and top level.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;   // length registers and window count
  localparam int IDX_W  = 4;   // config register index
  localparam int WORD_W = 64;  // packed pattern / replacement
  localparam int BYTES_MAX = 8;

  // config register indexes
  localparam logic [IDX_W-1:0] REG_PATTERN_BYTES  = 4'd0;
  localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 4'd1;
  localparam logic [IDX_W-1:0] REG_REPLACE_BYTES  = 4'd2;
  localparam logic [IDX_W-1:0] REG_REPLACE_LENGTH = 4'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  // per-cycle control shared by every cell of the window row
  typedef struct packed {
    logic shift;  // every cell takes its right neighbor's byte
    logic load;   // a new byte is appended at the tail
  } cell_ctrl_t;

endpackage

// File: rtl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window position: holds a pending byte, compares it against its
// pattern byte and passes its byte left on a shift.
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic                clk,
  input  sfr_pkg::cell_ctrl_t ctrl,
  input  logic                is_tail,    // this cell is the next free slot
  input  sfr_pkg::byte_t      load_byte,
  input  sfr_pkg::byte_t      right_byte, // neighbor toward the tail
  input  sfr_pkg::byte_t      pat_byte,
  output sfr_pkg::byte_t      byte_q,
  output logic                match
);
  import sfr_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.shift) begin
      byte_nxt = right_byte;
    end else if (ctrl.load && is_tail) begin
      byte_nxt = load_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;
  assign match  = (byte_r == pat_byte);

endmodule

// File: rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming find-and-replace over a byte string closed by an end item.
// ----------------------------------------------------------------------------
// Bytes arrive one per input transaction; in_tlast high marks the end item,
// whose byte is ignored. Every leftmost, non-overlapping occurrence of the
// configured pattern (1..8 bytes) is replaced by the replacement (0..8
// bytes). Bytes that still match a pattern prefix wait in a row of cells;
// when the held prefix fails, the front byte goes out literally and the rest
// is checked again. The end item flushes the row and then yields a status
// transaction (tlast high, char_valid low) whose pattern_found bit says
// whether any replacement happened. The block takes one item at a time: a
// byte is accepted, literal bytes it frees are released one by one, the
// window settles, and any replacement bytes follow; an end item first
// drains the held bytes, then sends its status. The output
// register is the only emission path, so one result leaves per cycle and a
// stalled out_tready holds the block. Config writes are taken at any time
// (cfg_ready is tied high) but belong to idle periods; writing the pattern
// or its length drops any held bytes.
// ----------------------------------------------------------------------------
`include "stream_find_and_replace_defines.svh"

module stream_find_and_replace #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPLACE = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] in_char
  input  logic                      in_tlast,   // end_of_string
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [7:0] out_char
  output logic [1:0]                out_tuser,  // [0] char_valid, [1] pattern_found
  output logic                      out_tlast,  // is_last
  // config writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sfr_pkg::IDX_W-1:0] cfg_index,
  input  logic [63:0]               cfg_data
);
  import sfr_pkg::*;

  // a pattern never exceeds 8 bytes, so no more cells than that are useful
  localparam int NCELL = (MAX_PATTERN < BYTES_MAX) ? MAX_PATTERN : BYTES_MAX;
  localparam int RLIM  = (MAX_REPLACE < BYTES_MAX) ? MAX_REPLACE : BYTES_MAX;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;  // resolve window after a new byte
  localparam logic [1:0] S_REPL  = 2'd2;  // emit replacement bytes
  localparam logic [1:0] S_FLUSH = 2'd3;  // end item: drain window, then status

  // config registers
  logic [WORD_W-1:0] pat_bytes_r, pat_bytes_nxt;
  logic [LEN_W-1:0]  pat_len_r,   pat_len_nxt;
  logic [WORD_W-1:0] rep_bytes_r, rep_bytes_nxt;
  logic [LEN_W-1:0]  rep_len_r,   rep_len_nxt;

  // control
  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;   // bytes held in the row
  logic [LEN_W-1:0] rep_cnt_r, rep_cnt_nxt;
  logic             found_r, found_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_char_r,  out_char_nxt;
  logic [1:0] out_user_r,  out_user_nxt;
  logic       out_last_r,  out_last_nxt;

  logic       in_acc, cfg_acc, can_emit;
  logic [LEN_W-1:0] plen, rlen, plen_raw;
  cell_ctrl_t ctrl;

  byte_t      cell_q [NCELL];
  logic [NCELL-1:0] match;
  logic [NCELL-1:0] in_win;
  logic       prefix;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign can_emit  = !out_valid_r || out_tready;

  // effective lengths: zero pattern acts as one; the pattern clamps to the cell row, the replacement to RLIM
  assign plen_raw = (pat_len_r == '0) ? LEN_W'(1) : pat_len_r;
  assign plen     = (plen_raw > LEN_W'(NCELL)) ? LEN_W'(NCELL) : plen_raw;
  assign rlen     = (rep_len_r > LEN_W'(RLIM)) ? LEN_W'(RLIM) : rep_len_r;

  // ---- cell row ----
  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      byte_t right_b;
      if (gi == NCELL - 1) begin : g_end
        assign right_b = '0;
      end else begin : g_mid
        assign right_b = cell_q[gi+1];
      end
      assign in_win[gi] = (LEN_W'(gi) < count_r);
      sfr_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .is_tail   (count_r == LEN_W'(gi)),
        .load_byte (in_tdata),
        .right_byte(right_b),
        .pat_byte  (pat_bytes_r[gi*BYTE_W +: BYTE_W]),
        .byte_q    (cell_q[gi]),
        .match     (match[gi])
      );
    end
  endgenerate

  // every held byte agrees with the pattern at its position
  assign prefix = &(match | ~in_win);

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rep_cnt_nxt   = rep_cnt_r;
    found_nxt     = found_r;
    ctrl          = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tlast) begin
            state_nxt = S_FLUSH;
          end else begin
            ctrl.load = 1'b1;
            count_nxt = count_r + LEN_W'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (prefix && count_r == plen) begin
          // full occurrence: drop it and send the replacement
          found_nxt   = 1'b1;
          count_nxt   = '0;
          rep_cnt_nxt = '0;
          state_nxt   = (rlen != '0) ? S_REPL : S_IDLE;
        end else if (prefix) begin
          state_nxt = S_IDLE;   // still a proper prefix, wait for more
        end else if (can_emit) begin
          // front byte is literal; shift and recheck the rest
          out_valid_nxt = 1'b1;
          out_char_nxt  = cell_q[0];
          out_user_nxt  = 2'b01;
          out_last_nxt  = 1'b0;
          ctrl.shift    = 1'b1;
          count_nxt     = count_r - LEN_W'(1);
        end
      end
      S_REPL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rep_bytes_r[{rep_cnt_r[2:0], 3'b000} +: BYTE_W];
          out_user_nxt  = 2'b01;
          out_last_nxt  = 1'b0;
          rep_cnt_nxt   = rep_cnt_r + LEN_W'(1);
          if (rep_cnt_nxt == rlen) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (count_r != '0) begin
            out_char_nxt = cell_q[0];
            out_user_nxt = 2'b01;
            out_last_nxt = 1'b0;
            ctrl.shift   = 1'b1;
            count_nxt    = count_r - LEN_W'(1);
          end else begin
            // status transaction
            out_char_nxt = '0;
            out_user_nxt = {found_r, 1'b0};
            out_last_nxt = 1'b1;
            found_nxt    = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // pattern rewrites discard held bytes
    if (cfg_acc && (cfg_index == REG_PATTERN_BYTES || cfg_index == REG_PATTERN_LENGTH)) begin
      count_nxt = '0;
    end
  end

  // ---- config decode ----
  always_comb begin
    pat_bytes_nxt = pat_bytes_r;
    pat_len_nxt   = pat_len_r;
    rep_bytes_nxt = rep_bytes_r;
    rep_len_nxt   = rep_len_r;
    if (cfg_acc) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  pat_bytes_nxt = cfg_data;
        REG_PATTERN_LENGTH: pat_len_nxt   = cfg_data[LEN_W-1:0];
        REG_REPLACE_BYTES:  rep_bytes_nxt = cfg_data;
        REG_REPLACE_LENGTH: rep_len_nxt   = cfg_data[LEN_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rep_cnt_r   <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pat_bytes_r <= '0;
      pat_len_r   <= LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      pat_bytes_r <= pat_bytes_nxt;
      pat_len_r   <= pat_len_nxt;
      rep_bytes_r <= rep_bytes_nxt;
      rep_len_r   <= rep_len_nxt;
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---- assertions ----
  // between items the row only ever holds a proper pattern prefix
  `SFR_ASSERT(a_win_short, (state_r == S_IDLE) |-> (count_r < plen))
  // replacement counter stays inside the replacement
  `SFR_ASSERT(a_rep_range, (state_r == S_REPL) |-> (rep_cnt_r < rlen))
  // the found flag is only raised by a full match during a scan
  `SFR_ASSERT(a_found_src, $rose(found_r) |-> $past(state_r == S_SCAN))
  // a status transaction never claims to carry a byte
  `SFR_ASSERT_ALWAYS(a_status_fmt, (out_valid_r && out_last_r) |-> !out_user_r[0])

endmodule
